### rtl/gtb_pkg.sv
package gtb_pkg;

	localparam int DIV_STAGES = 4;
	localparam int DIV_BITS_PER_STAGE = 3;

	typedef enum logic [1:0] {
		ST_DRAW    = 2'd0,
		ST_CLIPPED = 2'd1,
		ST_ERROR   = 2'd2
	} status_t;

	localparam logic [2:0] REG_TILES_PER_ROW      = 3'd0;
	localparam logic [2:0] REG_TILE_ROWS_PER_PAGE = 3'd1;
	localparam logic [2:0] REG_TILE_WIDTH         = 3'd2;
	localparam logic [2:0] REG_TILE_HEIGHT        = 3'd3;
	localparam logic [2:0] REG_ATLAS_WIDTH        = 3'd4;
	localparam logic [2:0] REG_ATLAS_HEIGHT       = 3'd5;
	localparam logic [2:0] REG_SURFACE_WIDTH      = 3'd6;
	localparam logic [2:0] REG_SURFACE_HEIGHT     = 3'd7;

	typedef struct packed {
		logic [6:0]  tiles_per_row;
		logic [6:0]  tile_rows_per_page;
		logic [6:0]  tile_width;
		logic [6:0]  tile_height;
		logic [12:0] atlas_width;
		logic [14:0] atlas_height;
		logic [12:0] surface_width;
		logic [12:0] surface_height;
	} cfg_t;

	typedef struct packed {
		logic [11:0]        glyph_number;
		logic [7:0]         cell_row;
		logic [7:0]         cell_column;
		logic signed [11:0] screen_origin_x;
		logic signed [11:0] screen_origin_y;
	} in_t;

	typedef struct packed {
		status_t     status;
		logic [11:0] source_x;
		logic [13:0] source_y;
		logic [11:0] target_x;
		logic [11:0] target_y;
		logic [6:0]  copy_width;
		logic [6:0]  copy_height;
	} out_t;

	typedef struct packed {
		in_t         req;
		logic [11:0] quo;
		logic [6:0]  rem;
	} div_t;

endpackage

### rtl/glyph_tile_blit_window.sv
// Maps one glyph draw request per cycle to a clipped blit window while out_ready does
// not stall the pipeline. Requests pass through the pipelined glyph / tiles_per_row
// divider (three quotient bits per stage), then placement, atlas bounds check and edge
// clipping. The atlas row is taken from the quotient and the column from the remainder,
// so the page size never needs a divider of its own. Configuration registers are read
// live and must only change while no request is in flight.
module glyph_tile_blit_window import gtb_pkg::*; #(
	parameter int MAX_TILE_SIZE    = 64,
	parameter int MAX_SURFACE_SIZE = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [14:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data
);

	cfg_t cfg_q;
	logic mid_valid, mid_ready;
	div_t mid_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{tiles_per_row: 7'd16, tile_rows_per_page: 7'd16, default: '0};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TILES_PER_ROW:      cfg_q.tiles_per_row      <= cfg_data[6:0];
				REG_TILE_ROWS_PER_PAGE: cfg_q.tile_rows_per_page <= cfg_data[6:0];
				REG_TILE_WIDTH:         cfg_q.tile_width         <= cfg_data[6:0];
				REG_TILE_HEIGHT:        cfg_q.tile_height        <= cfg_data[6:0];
				REG_ATLAS_WIDTH:        cfg_q.atlas_width        <= cfg_data[12:0];
				REG_ATLAS_HEIGHT:       cfg_q.atlas_height       <= cfg_data[14:0];
				REG_SURFACE_WIDTH:      cfg_q.surface_width      <= cfg_data[12:0];
				REG_SURFACE_HEIGHT:     cfg_q.surface_height     <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	gtb_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.divisor   (cfg_q.tiles_per_row),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_data  (mid_data)
	);

	gtb_clip #(
		.MAX_TILE_SIZE    (MAX_TILE_SIZE),
		.MAX_SURFACE_SIZE (MAX_SURFACE_SIZE)
	) u_clip (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.in_data   (mid_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

### rtl/gtb_div.sv
module gtb_div import gtb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [6:0] divisor,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_t        in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output div_t       out_data
);

	logic v_s  [DIV_STAGES];
	div_t pipe_s [DIV_STAGES];
	logic en   [DIV_STAGES];
	div_t src  [DIV_STAGES];
	div_t nx   [DIV_STAGES];

	assign src[0] = '{req: in_data, quo: '0, rem: '0};

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		if (g > 0) begin : g_src
			assign src[g] = pipe_s[g-1];
		end
		if (g == DIV_STAGES - 1) begin : g_last
			assign en[g] = !v_s[g] || out_ready;
		end else begin : g_mid
			assign en[g] = !v_s[g] || en[g+1];
		end

		// restoring division, three quotient bits per stage
		always_comb begin
			div_t       t;
			logic [7:0] part;
			int         idx;
			t = src[g];
			for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
				idx = 11 - DIV_BITS_PER_STAGE * g - j;
				part = {t.rem, t.req.glyph_number[idx]};
				if (part >= {1'b0, divisor}) begin
					part = part - {1'b0, divisor};
					t.quo[idx] = 1'b1;
				end
				t.rem = part[6:0];
			end
			nx[g] = t;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en[g]) begin
				v_s[g] <= (g == 0) ? in_valid : v_s[g-((g > 0) ? 1 : 0)];
			end
		end

		always_ff @(posedge clk) begin
			if (en[g]) begin
				pipe_s[g] <= nx[g];
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_s[DIV_STAGES-1];
	assign out_data  = pipe_s[DIV_STAGES-1];

endmodule

### rtl/gtb_clip.sv
module gtb_clip import gtb_pkg::*; #(
	parameter int MAX_TILE_SIZE    = 64,
	parameter int MAX_SURFACE_SIZE = 4096
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  div_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	logic en1, en2, en3, en4;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [13:0]        ax_s1;
	logic [18:0]        ay_s1;
	logic [14:0]        px_s1, py_s1;
	logic signed [11:0] ox_s1, oy_s1;

	logic signed [17:0] dx_s2, dy_s2;
	logic [13:0]        ax_s2;
	logic [18:0]        ay_s2;
	logic               err_s2;

	logic               err_s3, clip_s3;
	logic [19:0]        sx_s3, sy_s3;
	logic signed [17:0] dx0_s3, dy0_s3, cw0_s3, ch0_s3;

	out_t               out_s4;

	logic               layout_bad;
	logic signed [17:0] tw_x, th_x, sw_x, sh_x;

	assign tw_x = signed'({11'b0, cfg.tile_width});
	assign th_x = signed'({11'b0, cfg.tile_height});
	assign sw_x = signed'({5'b0, cfg.surface_width});
	assign sh_x = signed'({5'b0, cfg.surface_height});

	assign layout_bad = (cfg.surface_width == '0) || (cfg.surface_height == '0)
		|| (32'(cfg.surface_width) > MAX_SURFACE_SIZE)
		|| (32'(cfg.surface_height) > MAX_SURFACE_SIZE)
		|| (cfg.tiles_per_row == '0) || (cfg.tile_rows_per_page == '0)
		|| (cfg.tile_width == '0) || (cfg.tile_height == '0)
		|| (32'(cfg.tile_width) > MAX_TILE_SIZE)
		|| (32'(cfg.tile_height) > MAX_TILE_SIZE);

	assign en4 = !v_s4 || out_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// atlas and screen placement products
	always_ff @(posedge clk) begin
		if (en1) begin
			ax_s1 <= 14'(in_data.rem * cfg.tile_width);
			ay_s1 <= 19'(in_data.quo * cfg.tile_height);
			px_s1 <= 15'(in_data.req.cell_column * cfg.tile_width);
			py_s1 <= 15'(in_data.req.cell_row * cfg.tile_height);
			ox_s1 <= in_data.req.screen_origin_x;
			oy_s1 <= in_data.req.screen_origin_y;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			dx_s2  <= 18'(ox_s1) + signed'({3'b0, px_s1});
			dy_s2  <= 18'(oy_s1) + signed'({3'b0, py_s1});
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			err_s2 <= layout_bad
				|| ({1'b0, ax_s1} + {8'b0, cfg.tile_width} > {2'b0, cfg.atlas_width})
				|| ({1'b0, ay_s1} + {13'b0, cfg.tile_height} > {5'b0, cfg.atlas_height});
		end
	end

	// left and top edges
	always_ff @(posedge clk) begin
		if (en3) begin
			err_s3  <= err_s2;
			clip_s3 <= (dx_s2 >= sw_x) || (dy_s2 >= sh_x)
				|| (dx_s2 + tw_x <= 0) || (dy_s2 + th_x <= 0);
			if (dx_s2 < 0) begin
				sx_s3  <= 20'({6'b0, ax_s2} - 20'(dx_s2));
				cw0_s3 <= tw_x + dx_s2;
				dx0_s3 <= '0;
			end else begin
				sx_s3  <= {6'b0, ax_s2};
				cw0_s3 <= tw_x;
				dx0_s3 <= dx_s2;
			end
			if (dy_s2 < 0) begin
				sy_s3  <= 20'({1'b0, ay_s2} - 20'(dy_s2));
				ch0_s3 <= th_x + dy_s2;
				dy0_s3 <= '0;
			end else begin
				sy_s3  <= {1'b0, ay_s2};
				ch0_s3 <= th_x;
				dy0_s3 <= dy_s2;
			end
		end
	end

	// right and bottom edges, result word
	always_ff @(posedge clk) begin
		logic signed [17:0] cw, ch;
		out_t               res;
		if (en4) begin
			cw = (dx0_s3 + cw0_s3 > sw_x) ? sw_x - dx0_s3 : cw0_s3;
			ch = (dy0_s3 + ch0_s3 > sh_x) ? sh_x - dy0_s3 : ch0_s3;
			res = '0;
			if (err_s3) begin
				res.status = ST_ERROR;
			end else if (clip_s3 || cw <= 0 || ch <= 0) begin
				res.status = ST_CLIPPED;
			end else begin
				res.status      = ST_DRAW;
				res.source_x    = sx_s3[11:0];
				res.source_y    = sy_s3[13:0];
				res.target_x    = dx0_s3[11:0];
				res.target_y    = dy0_s3[11:0];
				res.copy_width  = cw[6:0];
				res.copy_height = ch[6:0];
			end
			out_s4 <= res;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = out_s4;

endmodule

### rtl/gtb_checker.sv
module gtb_checker import gtb_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input in_t         in_data,
	input logic        out_valid,
	input logic        out_ready,
	input out_t        out_data
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input word changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	a_no_draw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_DRAW |->
			out_data.source_x == '0 && out_data.source_y == '0
			&& out_data.target_x == '0 && out_data.target_y == '0
			&& out_data.copy_width == '0 && out_data.copy_height == '0)
		else $error("window fields set on a non-draw word");

	a_draw_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_DRAW |->
			out_data.copy_width != '0 && out_data.copy_height != '0)
		else $error("draw word with empty copy size");

endmodule

bind glyph_tile_blit_window gtb_checker u_gtb_checker (.*);

### verif/glyph_blit_checker.sv
`timescale 1ns / 100ps

module glyph_blit_checker import gtb_pkg::*; #(
	parameter int MAX_TILE_SIZE    = 64,
	parameter int MAX_SURFACE_SIZE = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [14:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_t         in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_t        out_data,
	output int          fail_count,
	output int          windows_pending
);

	cfg_t layout;
	out_t window_queue[$];

	function automatic out_t blank_window(status_t st);
		out_t r;
		r = '0;
		r.status = st;
		return r;
	endfunction

	function automatic out_t predict_window(in_t req);
		out_t r;
		longint tpr, trpp, tw, th, sw, sh, page_tiles, page, tile, tcol, trow;
		longint ax, ay, ox, oy, dx, dy, sx, sy, cw, ch;
		tpr  = layout.tiles_per_row;
		trpp = layout.tile_rows_per_page;
		tw   = layout.tile_width;
		th   = layout.tile_height;
		sw   = layout.surface_width;
		sh   = layout.surface_height;
		if (sw == 0 || sh == 0 || sw > MAX_SURFACE_SIZE || sh > MAX_SURFACE_SIZE)
			return blank_window(ST_ERROR);
		if (tpr == 0 || trpp == 0 || tw == 0 || th == 0 || tw > MAX_TILE_SIZE
				|| th > MAX_TILE_SIZE)
			return blank_window(ST_ERROR);
		page_tiles = tpr * trpp;
		page = longint'(req.glyph_number) / page_tiles;
		tile = longint'(req.glyph_number) % page_tiles;
		tcol = tile % tpr;
		trow = tile / tpr;
		ax = tcol * tw;
		ay = (page * trpp + trow) * th;
		if (ax + tw > longint'(layout.atlas_width) || ay + th > longint'(layout.atlas_height))
			return blank_window(ST_ERROR);
		ox = longint'($signed(req.screen_origin_x));
		oy = longint'($signed(req.screen_origin_y));
		dx = ox + longint'(req.cell_column) * tw;
		dy = oy + longint'(req.cell_row) * th;
		if (dx >= sw || dy >= sh || dx + tw <= 0 || dy + th <= 0)
			return blank_window(ST_CLIPPED);
		sx = ax;
		sy = ay;
		cw = tw;
		ch = th;
		if (dx < 0) begin
			sx -= dx;
			cw += dx;
			dx = 0;
		end
		if (dy < 0) begin
			sy -= dy;
			ch += dy;
			dy = 0;
		end
		if (dx + cw > sw)
			cw = sw - dx;
		if (dy + ch > sh)
			ch = sh - dy;
		if (cw <= 0 || ch <= 0)
			return blank_window(ST_CLIPPED);
		r.status      = ST_DRAW;
		r.source_x    = sx[11:0];
		r.source_y    = sy[13:0];
		r.target_x    = dx[11:0];
		r.target_y    = dy[11:0];
		r.copy_width  = cw[6:0];
		r.copy_height = ch[6:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout <= '{tiles_per_row: 7'd16, tile_rows_per_page: 7'd16, default: '0};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TILES_PER_ROW:      layout.tiles_per_row <= cfg_data[6:0];
				REG_TILE_ROWS_PER_PAGE: layout.tile_rows_per_page <= cfg_data[6:0];
				REG_TILE_WIDTH:         layout.tile_width <= cfg_data[6:0];
				REG_TILE_HEIGHT:        layout.tile_height <= cfg_data[6:0];
				REG_ATLAS_WIDTH:        layout.atlas_width <= cfg_data[12:0];
				REG_ATLAS_HEIGHT:       layout.atlas_height <= cfg_data[14:0];
				REG_SURFACE_WIDTH:      layout.surface_width <= cfg_data[12:0];
				REG_SURFACE_HEIGHT:     layout.surface_height <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		out_t want;
		if (!arst_n)
			fail_count = 0;
		if (arst_n && in_valid && in_ready)
			window_queue.push_back(predict_window(in_data));
		if (arst_n && out_valid && out_ready) begin
			if (window_queue.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected word: %p", out_data);
			end else begin
				want = window_queue.pop_front();
				if (out_data.status !== want.status || out_data.source_x !== want.source_x
						|| out_data.source_y !== want.source_y
						|| out_data.target_x !== want.target_x
						|| out_data.target_y !== want.target_y
						|| out_data.copy_width !== want.copy_width
						|| out_data.copy_height !== want.copy_height) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: expected %p got %p", want, out_data);
				end
			end
		end
	end

	// counted after this edge's push and pop
	always @(posedge clk) begin
		#0.1 windows_pending = window_queue.size();
	end

endmodule

### verif/tb_glyph_tile_blit_window.sv
`timescale 1ns / 100ps

module tb_glyph_tile_blit_window;
	import gtb_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_TILES_PER_ROW;
	logic [14:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_t         in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_t        out_data;
	int          fail_count;
	int          windows_pending;
	int          stall_cycles = 0;
	bit          quiet = 1'b0;
	bit          long_hold = 1'b0;
	cfg_t        cur;

	always #2 clk = ~clk;

	glyph_tile_blit_window DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	glyph_blit_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.fail_count(fail_count), .windows_pending(windows_pending)
	);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles > 3000) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver side
	initial begin
		int n;
		forever begin
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (120) @(posedge clk);
				long_hold = 1'b0;
			end else if (quiet) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				n = $urandom_range(1, 9);
				out_ready <= ($urandom_range(0, 3) != 0);
				repeat (n) @(posedge clk);
			end
		end
	end

	function automatic logic [14:0] reg_word(int val, int bits);
		logic [14:0] d;
		d = 15'($urandom);
		for (int i = 0; i < bits; i++)
			d[i] = val[i];
		return d;
	endfunction

	task automatic load_cfg(cfg_t c);
		cfg_we <= 1'b1;
		cfg_index <= REG_TILES_PER_ROW;
		cfg_data <= reg_word(c.tiles_per_row, 7);
		@(posedge clk);
		cfg_index <= REG_TILE_ROWS_PER_PAGE;
		cfg_data <= reg_word(c.tile_rows_per_page, 7);
		@(posedge clk);
		cfg_index <= REG_TILE_WIDTH;
		cfg_data <= reg_word(c.tile_width, 7);
		@(posedge clk);
		cfg_index <= REG_TILE_HEIGHT;
		cfg_data <= reg_word(c.tile_height, 7);
		@(posedge clk);
		cfg_index <= REG_ATLAS_WIDTH;
		cfg_data <= reg_word(c.atlas_width, 13);
		@(posedge clk);
		cfg_index <= REG_ATLAS_HEIGHT;
		cfg_data <= reg_word(c.atlas_height, 15);
		@(posedge clk);
		cfg_index <= REG_SURFACE_WIDTH;
		cfg_data <= reg_word(c.surface_width, 13);
		@(posedge clk);
		cfg_index <= REG_SURFACE_HEIGHT;
		cfg_data <= reg_word(c.surface_height, 13);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur = c;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (windows_pending != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic send_word(in_t w);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	function automatic in_t random_word();
		in_t w;
		int tw, th, span;
		tw = (cur.tile_width == 0) ? 1 : int'(cur.tile_width);
		th = (cur.tile_height == 0) ? 1 : int'(cur.tile_height);
		span = cur.tiles_per_row * cur.tile_rows_per_page * 2;
		w = in_t'({$urandom, $urandom});
		if ($urandom_range(0, 9) < 7) begin
			w.glyph_number = 12'($urandom_range(0, (span > 4095 || span == 0) ? 4095 : span));
			w.cell_column = 8'($urandom_range(0, (cur.surface_width / tw + 2 > 255) ? 255
				: cur.surface_width / tw + 2));
			w.cell_row = 8'($urandom_range(0, (cur.surface_height / th + 2 > 255) ? 255
				: cur.surface_height / th + 2));
			w.screen_origin_x = 12'($signed($urandom_range(0, 2 * tw)) - tw);
			w.screen_origin_y = 12'($signed($urandom_range(0, 2 * th)) - th);
		end
		return w;
	endfunction

	function automatic cfg_t random_cfg();
		cfg_t c;
		c.tiles_per_row = 7'($urandom_range(1, 64));
		c.tile_rows_per_page = 7'($urandom_range(1, 64));
		c.tile_width = 7'($urandom_range(1, 64));
		c.tile_height = 7'($urandom_range(1, 64));
		c.atlas_width = ($urandom_range(0, 5) == 0) ? 13'($urandom_range(0, 4096))
			: 13'(c.tiles_per_row * c.tile_width);
		c.atlas_height = 15'($urandom_range(0, 16384));
		c.surface_width = 13'($urandom_range(1, 4096));
		c.surface_height = 13'($urandom_range(1, 4096));
		if ($urandom_range(0, 7) == 0)
			c.tile_width = 7'($urandom_range(65, 127));
		if ($urandom_range(0, 7) == 0)
			c.surface_height = 13'($urandom_range(4097, 8191));
		return c;
	endfunction

	function automatic in_t mk(int g, int r, int col, int ox, int oy);
		in_t w;
		w.glyph_number = 12'(g);
		w.cell_row = 8'(r);
		w.cell_column = 8'(col);
		w.screen_origin_x = 12'(ox);
		w.screen_origin_y = 12'(oy);
		return w;
	endfunction

	initial begin
		cfg_t c;
		in_t w;
		cur = '0;
		cur.tiles_per_row = 16;
		cur.tile_rows_per_page = 16;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset layout has zero tile size
		send_word(mk(0, 0, 0, 0, 0));
		send_word(mk(4095, 255, 255, -1, -1));
		drain();

		c = '{7'd16, 7'd16, 7'd8, 7'd16, 13'd128, 15'd16384, 13'd640, 13'd480};
		load_cfg(c);
		send_word(mk(0, 0, 0, 0, 0));
		send_word(mk(17, 2, 3, 5, 7));
		send_word(mk(256, 0, 0, -4, -8));
		send_word(mk(300, 0, 79, 2047, 2047));
		send_word(mk(1, 29, 79, 4, 8));
		send_word(mk(2, 0, 0, -8, 0));
		send_word(mk(3, 0, 0, -2048, -2048));
		send_word(mk(4095, 255, 255, 0, 0));
		send_word(mk(1024, 0, 0, 0, 0));
		send_word(mk(5, 255, 0, -2048, -2048));
		drain();

		c = '{7'd64, 7'd64, 7'd64, 7'd64, 13'd4096, 15'd16384, 13'd4096, 13'd4096};
		load_cfg(c);
		send_word(mk(4095, 0, 0, -63, -63));
		send_word(mk(63, 63, 63, 0, 0));
		send_word(mk(64, 0, 0, -64, 0));
		send_word(mk(4095, 255, 255, -2048, -2048));
		long_hold = 1'b1;
		for (int i = 0; i < 40; i++)
			send_word(random_word());
		drain();

		c = '{7'd1, 7'd1, 7'd1, 7'd1, 13'd1, 15'd4096, 13'd1, 13'd1};
		load_cfg(c);
		send_word(mk(0, 0, 0, 0, 0));
		send_word(mk(4095, 0, 0, 0, 0));
		send_word(mk(4096 - 1, 1, 0, 0, 0));
		send_word(mk(2, 0, 0, 0, 0));
		send_word(mk(0, 0, 1, 0, 0));
		send_word(mk(0, 0, 0, -1, 0));
		drain();

		// invalid layouts and surfaces
		c = '{7'd0, 7'd16, 7'd8, 7'd8, 13'd4096, 15'd16384, 13'd640, 13'd480};
		load_cfg(c);
		send_word(mk(0, 0, 0, 0, 0));
		drain();
		c = '{7'd16, 7'd0, 7'd8, 7'd8, 13'd4096, 15'd16384, 13'd8191, 13'd0};
		load_cfg(c);
		send_word(mk(0, 0, 0, 0, 0));
		drain();
		c = '{7'd127, 7'd127, 7'd127, 7'd0, 13'd8191, 15'd32767, 13'd640, 13'd480};
		load_cfg(c);
		send_word(mk(0, 0, 0, 0, 0));
		drain();

		for (int p = 0; p < 12; p++) begin
			load_cfg(random_cfg());
			if (p == 11)
				quiet = 1'b1;
			for (int i = 0; i < 50; i++)
				send_word(random_word());
			drain();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### filelist.f
rtl/gtb_pkg.sv
rtl/gtb_div.sv
rtl/gtb_clip.sv
rtl/glyph_tile_blit_window.sv
rtl/gtb_checker.sv
verif/glyph_blit_checker.sv
verif/tb_glyph_tile_blit_window.sv
